FILE: rtl/core/sha256_stream_hasher_unit_macros.svh
// Assertion macros shared by the hasher checker.
// No dependencies; clk and rst must be visible at the point of use.
`ifndef SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_STREAM_HASHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SHA_HASHER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SHA_HASHER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sha_hasher_pkg.sv
// Constants, state codes and round functions of the SHA-256 stream hasher.
// Used by the top level and its checker; no dependencies.
package sha_hasher_pkg;

  localparam int unsigned DIGEST_WORDS = 8;
  localparam logic [2:0]  LAST_INDEX   = 3'd7;
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam logic [5:0]  LEN_START    = 6'd56;
  localparam logic [5:0]  LAST_SLOT    = 6'd63;
  localparam logic [5:0]  LAST_ROUND   = 6'd63;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROUND = 6'b000010,
    ST_FOLD  = 6'b000100,
    ST_PAD   = 6'b001000,
    ST_LEN   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  localparam logic [31:0] INIT_HASH [DIGEST_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: rtl/core/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher: one byte per beat in, eight digest words out.
// A byte beat is taken while idle; the beat that fills a block starts compression
// (64 rounds on one shared round unit, then the chaining add).
// End of message: padding feeds 9..72 bytes at one per cycle, pausing to compress
// each block that fills, then 8 output beats. Input stalls throughout.
// Reset: synchronous; clears control, length and chaining words. No clearing pass.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha_hasher_pkg::state_t state;
  sha_hasher_pkg::state_t resume;

  logic [31:0]  chain [sha_hasher_pkg::DIGEST_WORDS];
  logic [31:0]  vars  [sha_hasher_pkg::DIGEST_WORDS];
  logic [511:0] window;
  logic [63:0]  bits;
  logic [5:0]   fill;
  logic [5:0]   round;
  logic [2:0]   word_idx;
  logic         pad_first;

  logic         in_take;
  logic         byte_go;
  logic [7:0]   byte_val;
  logic         fill_full;
  logic [63:0]  len_word;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2, ch, mj;

  assign in_stall  = (state != sha_hasher_pkg::ST_IDLE);
  assign in_take   = in_valid && (state == sha_hasher_pkg::ST_IDLE);
  assign fill_full = (fill == sha_hasher_pkg::LAST_SLOT);
  assign len_word  = bits << {fill[2:0], 3'b000};

  assign out_valid   = (state == sha_hasher_pkg::ST_OUT);
  assign digest_word = chain[word_idx];
  assign word_index  = word_idx;
  assign last_word   = (word_idx == sha_hasher_pkg::LAST_INDEX);

  // Schedule window: oldest word sits in the top 32 bits.
  assign w0  = window[511:480];
  assign w1  = window[479:448];
  assign w9  = window[223:192];
  assign w14 = window[63:32];
  assign w_new = sha_hasher_pkg::small_sigma1(w14) + w9 +
                 sha_hasher_pkg::small_sigma0(w1) + w0;

  assign ch = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign mj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1 = vars[7] + sha_hasher_pkg::big_sigma1(vars[4]) + ch +
              sha_hasher_pkg::ROUND_K[round] + w0;
  assign t2 = sha_hasher_pkg::big_sigma0(vars[0]) + mj;

  always_comb begin
    byte_go  = 1'b0;
    byte_val = data_byte;
    unique case (state)
      sha_hasher_pkg::ST_IDLE: begin
        byte_go = in_take && byte_present;
      end
      sha_hasher_pkg::ST_PAD: begin
        byte_go  = 1'b1;
        byte_val = pad_first ? sha_hasher_pkg::PAD_MARK : 8'h00;
      end
      sha_hasher_pkg::ST_LEN: begin
        byte_go  = 1'b1;
        byte_val = len_word[63:56];
      end
      default: begin
        byte_go = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sha_hasher_pkg::ST_IDLE;
      resume    <= sha_hasher_pkg::ST_IDLE;
      chain     <= sha_hasher_pkg::INIT_HASH;
      bits      <= 64'd0;
      fill      <= 6'd0;
      round     <= 6'd0;
      word_idx  <= 3'd0;
      pad_first <= 1'b0;
    end else begin
      // Shift window: a byte while loading, a schedule word while compressing.
      if (state == sha_hasher_pkg::ST_ROUND) begin
        window <= {window[479:0], w_new};
      end else if (byte_go) begin
        window <= {window[503:0], byte_val};
      end
      if (byte_go) begin
        fill <= fill + 6'd1;
      end

      unique case (state)
        sha_hasher_pkg::ST_IDLE: begin
          if (in_take) begin
            pad_first <= 1'b1;
            if (byte_present) begin
              bits <= bits + 64'd8;
            end
            if (byte_present && fill_full) begin
              state  <= sha_hasher_pkg::ST_ROUND;
              vars   <= chain;
              round  <= 6'd0;
              resume <= end_of_message ? sha_hasher_pkg::ST_PAD : sha_hasher_pkg::ST_IDLE;
            end else if (end_of_message) begin
              state <= sha_hasher_pkg::ST_PAD;
            end
          end
        end
        sha_hasher_pkg::ST_PAD: begin
          pad_first <= 1'b0;
          if (fill_full) begin
            state  <= sha_hasher_pkg::ST_ROUND;
            vars   <= chain;
            round  <= 6'd0;
            resume <= sha_hasher_pkg::ST_PAD;
          end else if (fill == sha_hasher_pkg::LEN_START - 6'd1) begin
            state <= sha_hasher_pkg::ST_LEN;
          end
        end
        sha_hasher_pkg::ST_LEN: begin
          if (fill_full) begin
            state  <= sha_hasher_pkg::ST_ROUND;
            vars   <= chain;
            round  <= 6'd0;
            resume <= sha_hasher_pkg::ST_OUT;
          end
        end
        sha_hasher_pkg::ST_ROUND: begin
          vars[7] <= vars[6];
          vars[6] <= vars[5];
          vars[5] <= vars[4];
          vars[4] <= vars[3] + t1;
          vars[3] <= vars[2];
          vars[2] <= vars[1];
          vars[1] <= vars[0];
          vars[0] <= t1 + t2;
          round   <= round + 6'd1;
          if (round == sha_hasher_pkg::LAST_ROUND) begin
            state <= sha_hasher_pkg::ST_FOLD;
          end
        end
        sha_hasher_pkg::ST_FOLD: begin
          for (int j = 0; j < sha_hasher_pkg::DIGEST_WORDS; j++) begin
            chain[j] <= chain[j] + vars[j];
          end
          word_idx <= 3'd0;
          state    <= resume;
        end
        sha_hasher_pkg::ST_OUT: begin
          if (!out_stall) begin
            if (word_idx == sha_hasher_pkg::LAST_INDEX) begin
              // Drop the finished message and start over.
              chain <= sha_hasher_pkg::INIT_HASH;
              bits  <= 64'd0;
              state <= sha_hasher_pkg::ST_IDLE;
            end else begin
              word_idx <= word_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= sha_hasher_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/sha_hasher_chk.sv
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha_hasher_pkg and sha256_stream_hasher_unit_macros.svh.
`include "sha256_stream_hasher_unit_macros.svh"

module sha_hasher_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // Input is held off while digest beats are pending.
  `SHA_HASHER_ASSERT_NOW(a_no_input_during_output, out_valid, in_stall, "input taken during digest output")

  `SHA_HASHER_ASSERT_NEXT(a_hold_stalled, out_valid && out_stall, out_valid && $stable(digest_word) && $stable(word_index), "stalled digest beat changed")

  // Digest beats advance one index at a time.
  `SHA_HASHER_ASSERT_NEXT(a_index_steps, out_valid && !out_stall && !last_word, out_valid && (word_index == 3'($past(word_index) + 3'd1)), "digest index skipped")

  `SHA_HASHER_ASSERT_NEXT(a_ready_after_last, out_valid && !out_stall && (word_index == sha_hasher_pkg::LAST_INDEX), !out_valid && !in_stall, "not ready after last digest beat")

  // A beat that does not close the message produces no output.
  `SHA_HASHER_ASSERT_NEXT(a_no_spurious_output, in_valid && !in_stall && !end_of_message, !out_valid, "output without end of message")

endmodule

bind sha256_stream_hasher_unit sha_hasher_chk u_sha_hasher_chk (.*);
